// ----- sv/udc_pkg.sv -----
// ----------------------------------------------------------------------------
// udc_pkg
// Shared types, constants and helpers for the udp datagram check and
// checksum unit.
// ----------------------------------------------------------------------------
package udc_pkg;

  localparam int unsigned MAX_DATAGRAM = 65535;
  // byte count saturates at MAX_DATAGRAM + 1
  localparam int unsigned CNT_W        = $clog2(MAX_DATAGRAM + 2);
  localparam int unsigned HDR_BYTES    = 8;
  localparam int unsigned HDR_AW       = $clog2(HDR_BYTES);
  localparam int unsigned SUM_W        = 18;
  localparam int unsigned Q_DEPTH      = 2;
  localparam int unsigned Q_AW         = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned IN_DATA_W    = 8;
  localparam int unsigned IN_USER_W    = 3;
  localparam int unsigned OUT_DATA_W   = 104;

  localparam logic [15:0] UDP_PROTO = 16'd17;
  localparam logic [15:0] ALL_ONES  = 16'hFFFF;

  // input item kinds
  localparam logic [1:0] CMD_SRC   = 2'd0;
  localparam logic [1:0] CMD_DST   = 2'd1;
  localparam logic [1:0] CMD_DGRAM = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_EN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'b1;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_FAMILY   = 3'd1,
    ERR_SHORT    = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_CHECKSUM = 3'd4
  } err_t;

  // what the back end needs to finish a datagram
  typedef struct packed {
    logic        gen;
    logic        chk_req;
    err_t        pre_err;
    logic [15:0] len_add;
    logic [63:0] hdr;
  } fin_info_t;

  typedef struct packed {
    logic       add_en;
    logic [7:0] data_byte;
    logic       fin;
    fin_info_t  info;
  } q_entry_t;

  typedef struct packed {
    err_t        error;
    logic [15:0] src_port;
    logic [15:0] dest_port;
    logic [15:0] udp_len;
    logic [15:0] checksum_field;
    logic [15:0] payload_len;
    logic [15:0] computed_checksum;
  } result_t;

  // one's-complement add with end-around carry
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- sv/udc_front.sv -----
// ----------------------------------------------------------------------------
// udc_front
// Accepts input bytes, tracks families, header bytes and the byte count,
// and classifies each byte into a request for the back end.
// ----------------------------------------------------------------------------
module udc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [7:0]             data_byte,
  input  logic                   is_ipv6,
  input  logic                   last,
  input  logic                   check_en,
  input  logic                   mode,
  input  logic                   q_ready,
  output logic                   q_push,
  output udc_pkg::q_entry_t      q_entry
);

  logic                        src_v6_r, src_v6_nxt;
  logic                        dst_v6_r, dst_v6_nxt;
  logic [udc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]                  hdr_r [udc_pkg::HDR_BYTES];
  logic [7:0]                  hdr_nxt [udc_pkg::HDR_BYTES];
  logic                        accept;
  logic                        is_addr, is_dg, fin;
  logic                        hdr_wr;
  logic [15:0]                 ulen_cur, ulen, ck;
  logic [63:0]                 hdr_flat;
  udc_pkg::err_t               pre_err;
  logic                        chk_req;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign is_addr  = (cmd == udc_pkg::CMD_SRC) || (cmd == udc_pkg::CMD_DST);
  assign is_dg    = (cmd == udc_pkg::CMD_DGRAM);
  assign fin      = is_dg && last;
  assign hdr_wr   = is_dg && (cnt_r < udc_pkg::CNT_W'(udc_pkg::HDR_BYTES));

  // length field as seen before this byte lands
  assign ulen_cur = {hdr_r[4], hdr_r[5]};

  always_comb begin
    for (int j = 0; j < udc_pkg::HDR_BYTES; j++) begin
      if (hdr_wr && (cnt_r[udc_pkg::HDR_AW-1:0] == udc_pkg::HDR_AW'(j))) begin
        hdr_nxt[j] = data_byte;
      end else begin
        hdr_nxt[j] = hdr_r[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < udc_pkg::HDR_BYTES; j++) begin
      hdr_flat[63-8*j -: 8] = hdr_nxt[j];
    end
  end

  assign ulen = {hdr_nxt[4], hdr_nxt[5]};
  assign ck   = {hdr_nxt[6], hdr_nxt[7]};

  assign cnt_inc = (cnt_r <= udc_pkg::CNT_W'(udc_pkg::MAX_DATAGRAM)) ?
                   cnt_r + udc_pkg::CNT_W'(1) : cnt_r;

  // checks that do not need the sum
  always_comb begin
    pre_err = udc_pkg::ERR_OK;
    chk_req = 1'b0;
    if (src_v6_r != dst_v6_r) begin
      pre_err = udc_pkg::ERR_FAMILY;
    end else if (cnt_inc < udc_pkg::CNT_W'(udc_pkg::HDR_BYTES)) begin
      pre_err = udc_pkg::ERR_SHORT;
    end else if (mode) begin
      if (cnt_inc > udc_pkg::CNT_W'(udc_pkg::MAX_DATAGRAM)) begin
        pre_err = udc_pkg::ERR_LENGTH;
      end
    end else if ((ulen < 16'(udc_pkg::HDR_BYTES)) ||
                 (udc_pkg::CNT_W'(ulen) > cnt_inc) ||
                 (udc_pkg::CNT_W'(ulen) > udc_pkg::CNT_W'(udc_pkg::MAX_DATAGRAM))) begin
      pre_err = udc_pkg::ERR_LENGTH;
    end else if (check_en) begin
      if (ck == 16'd0) begin
        // zero checksum means none sent: fine on v4, not allowed on v6
        if (src_v6_r) begin
          pre_err = udc_pkg::ERR_CHECKSUM;
        end
      end else begin
        chk_req = 1'b1;
      end
    end
  end

  always_comb begin
    q_entry                = '0;
    q_entry.data_byte      = data_byte;
    q_entry.fin            = fin;
    // past the length field only bytes inside udp_len count in parse mode
    q_entry.add_en         = is_addr || mode || (cnt_r < udc_pkg::CNT_W'(6)) ||
                             (cnt_r < udc_pkg::CNT_W'(ulen_cur));
    q_entry.info.gen       = mode;
    q_entry.info.chk_req   = chk_req;
    q_entry.info.pre_err   = pre_err;
    q_entry.info.len_add   = mode ? cnt_inc[15:0] : ulen;
    q_entry.info.hdr       = hdr_flat;
  end

  assign q_push = accept && (is_addr || is_dg);

  always_comb begin
    src_v6_nxt = src_v6_r;
    dst_v6_nxt = dst_v6_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      if (cmd == udc_pkg::CMD_SRC) begin
        src_v6_nxt = is_ipv6;
      end
      if (cmd == udc_pkg::CMD_DST) begin
        dst_v6_nxt = is_ipv6;
      end
      if (is_dg) begin
        cnt_nxt = cnt_inc;
      end
      if (fin) begin
        src_v6_nxt = 1'b0;
        dst_v6_nxt = 1'b0;
        cnt_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_v6_r <= 1'b0;
      dst_v6_r <= 1'b0;
      cnt_r    <= '0;
      for (int j = 0; j < udc_pkg::HDR_BYTES; j++) begin
        hdr_r[j] <= '0;
      end
    end else begin
      src_v6_r <= src_v6_nxt;
      dst_v6_r <= dst_v6_nxt;
      cnt_r    <= cnt_nxt;
      if (accept) begin
        for (int j = 0; j < udc_pkg::HDR_BYTES; j++) begin
          hdr_r[j] <= fin ? 8'd0 : hdr_nxt[j];
        end
      end
    end
  end

endmodule

// ----- sv/udc_queue.sv -----
// ----------------------------------------------------------------------------
// udc_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module udc_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  udc_pkg::q_entry_t      push_entry,
  output logic                   ready,
  input  logic                   pop,
  output logic                   valid,
  output udc_pkg::q_entry_t      head
);

  udc_pkg::q_entry_t          mem_r [udc_pkg::Q_DEPTH];
  logic [udc_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [udc_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [udc_pkg::Q_AW:0]     cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign ready   = (cnt_r != (udc_pkg::Q_AW+1)'(udc_pkg::Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == udc_pkg::Q_AW'(udc_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + udc_pkg::Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == udc_pkg::Q_AW'(udc_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + udc_pkg::Q_AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (udc_pkg::Q_AW+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - (udc_pkg::Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- sv/udc_back.sv -----
// ----------------------------------------------------------------------------
// udc_back
// Pairs bytes into 16-bit words and keeps the one's-complement sum; on the
// final byte adds the pseudo-header, checks or forms the checksum and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module udc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  udc_pkg::q_entry_t      q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output udc_pkg::result_t       out_res
);

  // word accumulation
  logic [15:0]               acc_r, acc_nxt, a_acc;
  logic [7:0]                pend_r, pend_nxt, a_pend;
  logic                      odd_r, odd_nxt, a_odd;

  // snapshot of the stream at its final byte
  logic                      snap_v_r;
  logic [15:0]               snap_acc_r;
  logic [7:0]                snap_pend_r;
  logic                      snap_odd_r;
  udc_pkg::fin_info_t        snap_info_r;

  // pseudo-header sum
  logic                      sum_v_r;
  logic [udc_pkg::SUM_W-1:0] sum_r, sum_nxt;
  udc_pkg::fin_info_t        sum_info_r;

  logic                      out_v_r;
  udc_pkg::result_t          res_r, res_nxt;

  logic                      snap_ready, sum_ready, o_ready;
  logic                      take_fin;
  logic [16:0]               fold1;
  logic [15:0]               total, inv;
  udc_pkg::err_t             err;

  assign o_ready    = !out_v_r || out_ready;
  assign sum_ready  = !sum_v_r || o_ready;
  assign snap_ready = !snap_v_r || sum_ready;
  assign q_pop      = q_valid && (!q_head.fin || snap_ready);
  assign take_fin   = q_pop && q_head.fin;

  always_comb begin
    a_acc  = acc_r;
    a_pend = pend_r;
    a_odd  = odd_r;
    if (q_pop && q_head.add_en) begin
      if (!odd_r) begin
        a_pend = q_head.data_byte;
        a_odd  = 1'b1;
      end else begin
        a_acc = udc_pkg::ones_add(acc_r, {pend_r, q_head.data_byte});
        a_odd = 1'b0;
      end
    end
    acc_nxt  = take_fin ? 16'd0 : a_acc;
    pend_nxt = take_fin ? 8'd0  : a_pend;
    odd_nxt  = take_fin ? 1'b0  : a_odd;
  end

  // odd tail padded with a zero low byte, then protocol and length
  assign sum_nxt = udc_pkg::SUM_W'(snap_acc_r) +
                   udc_pkg::SUM_W'(snap_odd_r ? {snap_pend_r, 8'd0} : 16'd0) +
                   udc_pkg::SUM_W'(udc_pkg::UDP_PROTO) +
                   udc_pkg::SUM_W'(snap_info_r.len_add);

  assign fold1 = {1'b0, sum_r[15:0]} + 17'(sum_r[udc_pkg::SUM_W-1:16]);
  assign total = fold1[15:0] + {15'd0, fold1[16]};
  assign inv   = ~total;

  always_comb begin
    if (sum_info_r.pre_err != udc_pkg::ERR_OK) begin
      err = sum_info_r.pre_err;
    end else if (sum_info_r.chk_req && (inv != 16'd0)) begin
      err = udc_pkg::ERR_CHECKSUM;
    end else begin
      err = udc_pkg::ERR_OK;
    end
  end

  always_comb begin
    res_nxt       = '0;
    res_nxt.error = err;
    if (err == udc_pkg::ERR_OK) begin
      if (sum_info_r.gen) begin
        // zero goes out as all ones
        res_nxt.computed_checksum = (inv == 16'd0) ? udc_pkg::ALL_ONES : inv;
      end else begin
        res_nxt.src_port       = sum_info_r.hdr[63:48];
        res_nxt.dest_port      = sum_info_r.hdr[47:32];
        res_nxt.udp_len        = sum_info_r.hdr[31:16];
        res_nxt.checksum_field = sum_info_r.hdr[15:0];
        res_nxt.payload_len    = sum_info_r.hdr[31:16] - 16'(udc_pkg::HDR_BYTES);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      pend_r   <= '0;
      odd_r    <= 1'b0;
      snap_v_r <= 1'b0;
      sum_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      odd_r  <= odd_nxt;
      if (snap_ready) begin
        snap_v_r <= take_fin;
      end
      if (sum_ready) begin
        sum_v_r <= snap_v_r;
      end
      if (o_ready) begin
        out_v_r <= sum_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_fin) begin
      snap_acc_r  <= a_acc;
      snap_pend_r <= a_pend;
      snap_odd_r  <= a_odd;
      snap_info_r <= q_head.info;
    end
    if (snap_v_r && sum_ready) begin
      sum_r      <= sum_nxt;
      sum_info_r <= snap_info_r;
    end
    if (sum_v_r && o_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = res_r;

endmodule

// ----- sv/udp_datagram_check_and_checksum_unit.sv -----
// ----------------------------------------------------------------------------
// udp_datagram_check_and_checksum_unit
// Parses and checks received udp datagrams, or computes the transmit
// checksum, from a byte stream of addresses and datagram bytes.
//
//   channel  dir  handshake                  payload
//   in_      in   in_tvalid / in_tready      tdata: data_byte
//                                            tuser: cmd, is_ipv6; tlast: last
//   out_     out  out_tvalid / out_tready    tdata: result fields
//   cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One byte is accepted per cycle while in_tready is high; the word adder in the
// back end takes one request per cycle from a two-entry queue, but for the stall below.
// A result passes the queue, the sum snapshot, the pseudo-header add and the output
// register before it shows on out_tvalid.
// rst_n is synchronous; check_enable resets to 1 and mode to 0.
// A stalled output holds the back end only at a final byte; the queue then
// fills and in_tready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module udp_datagram_check_and_checksum_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [udc_pkg::IN_DATA_W-1:0]       in_tdata,   // data_byte[7:0]
  input  logic [udc_pkg::IN_USER_W-1:0]       in_tuser,   // cmd[1:0], is_ipv6[2]
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // error[2:0], src_port[18:3], dest_port[34:19], udp_len[50:35],
  // checksum_field[66:51], payload_len[82:67], computed_checksum[98:83], zero above
  output logic [udc_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [udc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic                                cfg_data
);

  logic                check_en_r;
  logic                mode_r;
  logic                q_push, q_ready, q_pop, q_valid;
  udc_pkg::q_entry_t   q_in, q_head;
  udc_pkg::result_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_en_r <= 1'b1;
      mode_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        udc_pkg::REG_CHECK_EN: check_en_r <= cfg_data;
        udc_pkg::REG_MODE:     mode_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  udc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tuser[1:0]),
    .data_byte (in_tdata),
    .is_ipv6   (in_tuser[2]),
    .last      (in_tlast),
    .check_en  (check_en_r),
    .mode      (mode_r),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  udc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .ready      (q_ready),
    .pop        (q_pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  udc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {5'd0, res.computed_checksum, res.payload_len, res.checksum_field,
                      res.udp_len, res.dest_port, res.src_port, res.error};

`ifndef SYNTH
  // any error leaves every other field zero
  a_err_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] != udc_pkg::ERR_OK) |-> (out_tdata[98:3] == '0))
    else $error("result fields not cleared on error");

  // a parse result carries payload length tied to udp length
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == udc_pkg::ERR_OK) && (out_tdata[98:83] == 16'd0)
    |-> (out_tdata[82:67] == out_tdata[50:35] - 16'd8))
    else $error("payload length does not match udp length");

  // a generate result never carries header fields and never a zero checksum
  a_gen_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[98:83] != 16'd0) |-> (out_tdata[82:0] == '0))
    else $error("generate result carries parse fields");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");
`endif

endmodule
